// ===== rtl/core/skd_pkg.sv =====
// Shared types, constants and the scan-code key map for the key event decoder.
`timescale 1ns / 1ps

package skd_pkg;

	// Scan-code set 1 extended prefix and the release flag position
	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam int         RELEASE_BIT = 7;

	// Width of a key index and of the event number on the result side
	localparam int KEY_W   = 7;
	localparam int EVENT_W = 32;

	// Depth of each small queue and the widths of its pointer and count
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// One classified key request from the front part
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             down;
	} key_req_t;

	// One finished key event waiting at the result side
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic               down;
		logic [EVENT_W-1:0] number;
	} key_event_t;

	// Result of a key map lookup
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} lookup_t;

	// Key map: address is {extended flag, 7-bit code}, key index in table order
	function automatic lookup_t key_lookup(input logic [7:0] addr);
		lookup_t r;
		r.valid = 1'b1;
		r.key   = '0;
		case (addr)
			8'h0B: r.key = 7'd0;
			8'h02: r.key = 7'd1;
			8'h03: r.key = 7'd2;
			8'h04: r.key = 7'd3;
			8'h05: r.key = 7'd4;
			8'h06: r.key = 7'd5;
			8'h07: r.key = 7'd6;
			8'h08: r.key = 7'd7;
			8'h09: r.key = 7'd8;
			8'h0A: r.key = 7'd9;
			8'h1E: r.key = 7'd10;
			8'h30: r.key = 7'd11;
			8'h2E: r.key = 7'd12;
			8'h20: r.key = 7'd13;
			8'h12: r.key = 7'd14;
			8'h21: r.key = 7'd15;
			8'h22: r.key = 7'd16;
			8'h23: r.key = 7'd17;
			8'h17: r.key = 7'd18;
			8'h24: r.key = 7'd19;
			8'h25: r.key = 7'd20;
			8'h26: r.key = 7'd21;
			8'h32: r.key = 7'd22;
			8'h31: r.key = 7'd23;
			8'h18: r.key = 7'd24;
			8'h19: r.key = 7'd25;
			8'h10: r.key = 7'd26;
			8'h13: r.key = 7'd27;
			8'h1F: r.key = 7'd28;
			8'h14: r.key = 7'd29;
			8'h16: r.key = 7'd30;
			8'h2F: r.key = 7'd31;
			8'h11: r.key = 7'd32;
			8'h2D: r.key = 7'd33;
			8'h15: r.key = 7'd34;
			8'h2C: r.key = 7'd35;
			8'h39: r.key = 7'd36;
			8'h0E: r.key = 7'd37;
			8'h1C: r.key = 7'd38;
			8'h01: r.key = 7'd39;
			8'hCB: r.key = 7'd40;
			8'hC8: r.key = 7'd41;
			8'hCD: r.key = 7'd42;
			8'hD0: r.key = 7'd43;
			8'h2A: r.key = 7'd44;
			8'h36: r.key = 7'd45;
			8'h1D: r.key = 7'd46;
			8'h9D: r.key = 7'd47;
			8'h38: r.key = 7'd48;
			8'hB8: r.key = 7'd49;
			8'h52: r.key = 7'd50;
			8'h4F: r.key = 7'd51;
			8'h50: r.key = 7'd52;
			8'h51: r.key = 7'd53;
			8'h4B: r.key = 7'd54;
			8'h4C: r.key = 7'd55;
			8'h4D: r.key = 7'd56;
			8'h47: r.key = 7'd57;
			8'h48: r.key = 7'd58;
			8'h49: r.key = 7'd59;
			8'hB7: r.key = 7'd60;
			8'hB5: r.key = 7'd61;
			8'h4E: r.key = 7'd62;
			8'h4A: r.key = 7'd63;
			8'h9C: r.key = 7'd64;
			default: begin
				r.valid = 1'b0;
				r.key   = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/skd_front.sv =====
// Front part: accepts scan bytes, tracks the prefix, looks up keys, queues key requests.
`timescale 1ns / 1ps

module skd_front #(
	parameter int NUM_KEYS = 65
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        scan_byte,
	input  logic              push,
	output logic              full,
	output logic              req_valid,
	output skd_pkg::key_req_t req,
	input  logic              req_take
);
	import skd_pkg::*;

	logic               prefix_q;
	key_req_t           qbuf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	logic     accept;
	logic     is_prefix;
	lookup_t  lk;
	logic     hit;
	logic     deq;
	key_req_t new_req;

	// Classify the incoming byte against the key map
	assign accept    = push & ~full;
	assign is_prefix = (scan_byte == PREFIX_BYTE);
	assign lk        = key_lookup({prefix_q, scan_byte[6:0]});
	assign hit       = accept & ~is_prefix & lk.valid & (int'(lk.key) < NUM_KEYS);
	assign new_req.key  = lk.key;
	assign new_req.down = ~scan_byte[RELEASE_BIT];

	// Queue status towards both sides
	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign req_valid = (cnt_q != '0);
	assign req       = qbuf_q[rd_ptr_q];
	assign deq       = req_take & req_valid;

	// Hold the prefix flag and advance the queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				prefix_q <= is_prefix;
			end
			if (hit) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (hit && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!hit && deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the key request in the free slot
	always_ff @(posedge clk) begin
		if (hit) begin
			qbuf_q[wr_ptr_q] <= new_req;
		end
	end

endmodule

// ===== rtl/core/skd_back.sv =====
// Back part: pressed-key bitmap, event counter and the result queue.
`timescale 1ns / 1ps

module skd_back #(
	parameter int NUM_KEYS          = 65,
	parameter int EVENT_COUNT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  skd_pkg::key_req_t            req,
	output logic                         req_take,
	output logic                         empty,
	input  logic                         pop,
	output logic [skd_pkg::KEY_W-1:0]    key_number,
	output logic                         key_down,
	output logic [skd_pkg::EVENT_W-1:0]  event_number
);
	import skd_pkg::*;

	localparam int MAP_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [NUM_KEYS-1:0]          pressed_q;
	logic [EVENT_COUNT_WIDTH-1:0] count_q;
	key_event_t                   obuf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]            wr_ptr_q;
	logic [QPTR_W-1:0]            rd_ptr_q;
	logic [QCNT_W-1:0]            cnt_q;

	logic              out_full;
	logic [MAP_AW-1:0] map_idx;
	logic              change;
	logic              emit;
	logic              deq;
	key_event_t        new_ev;
	key_event_t        head;

	// Take a request whenever the result queue has room
	assign out_full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign req_take = req_valid & ~out_full;
	assign map_idx  = MAP_AW'(req.key);
	assign change   = (pressed_q[map_idx] != req.down);
	assign emit     = req_take & change;

	assign new_ev.key    = req.key;
	assign new_ev.down   = req.down;
	assign new_ev.number = EVENT_W'(count_q);

	// Present the oldest event
	assign empty        = (cnt_q == '0);
	assign deq          = pop & ~empty;
	assign head         = obuf_q[rd_ptr_q];
	assign key_number   = head.key;
	assign key_down     = head.down;
	assign event_number = head.number;

	// Update the bitmap, count events and advance the queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
			count_q   <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
		end else begin
			if (emit) begin
				pressed_q[map_idx] <= req.down;
				count_q            <= count_q + 1'b1;
				wr_ptr_q           <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (emit && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!emit && deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the new event
	always_ff @(posedge clk) begin
		if (emit) begin
			obuf_q[wr_ptr_q] <= new_ev;
		end
	end

endmodule

// ===== rtl/core/scancode_key_event_decoder_unit.sv =====
// Top level of the scan-code set 1 key event decoder.
// Usage:
//   Input queue: drive scan_byte and raise push; a byte is taken at a rising
//   edge with push high and full low. One byte can be taken every cycle while full is low.
//   The byte E0 only arms the extended prefix; other bytes are looked up with
//   the prefix, which is then dropped. Unknown codes give nothing.
//   Result queue: while empty is low, key_number, key_down and event_number
//   show the oldest key event; pop at an edge with empty low takes it.
//   A press of a key already held, or a release of a key not held, gives no
//   event. event_number counts events from zero and wraps.
//   Path: the request for a taken byte is registered in the request queue;
//   the bitmap stage then takes it when the result queue has room and writes
//   the event into the result queue, from which pop can take it.
//   Throughput: one byte per cycle while full is low; the map lookup and the
//   bitmap read of the read-modify-write are combinational.
//   Stall: if pop stays low the two-entry result queue fills, then the
//   two-entry request queue, after which full rises; nothing is lost.
//   Reset (arst_n low): prefix, bitmap, counter and both queues clear at once.
`timescale 1ns / 1ps

module scancode_key_event_decoder_unit #(
	parameter int NUM_KEYS          = 65,
	parameter int EVENT_COUNT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [7:0]                   scan_byte,
	input  logic                         push,
	output logic                         full,
	output logic [skd_pkg::KEY_W-1:0]    key_number,
	output logic                         key_down,
	output logic [skd_pkg::EVENT_W-1:0]  event_number,
	output logic                         empty,
	input  logic                         pop
);
	import skd_pkg::*;

	logic     mid_valid;
	key_req_t mid_req;
	logic     mid_take;

	// Accept and classify bytes
	skd_front #(
		.NUM_KEYS (NUM_KEYS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_byte (scan_byte),
		.push      (push),
		.full      (full),
		.req_valid (mid_valid),
		.req       (mid_req),
		.req_take  (mid_take)
	);

	// Track key state and deliver events
	skd_back #(
		.NUM_KEYS          (NUM_KEYS),
		.EVENT_COUNT_WIDTH (EVENT_COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (mid_valid),
		.req          (mid_req),
		.req_take     (mid_take),
		.empty        (empty),
		.pop          (pop),
		.key_number   (key_number),
		.key_down     (key_down),
		.event_number (event_number)
	);

`ifndef SYNTHESIS
	// A request handed to the back part always names a tracked key
	a_key_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mid_take |-> (int'(mid_req.key) < NUM_KEYS))
		else $error("key request outside the bitmap");

	// An event appears only after the back part took a request
	a_event_source: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(mid_take))
		else $error("event appeared without a request");

	// The input side fills only after a byte was taken
	a_full_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted byte");
`endif

endmodule

// ===== dv/skd_checker.sv =====
// Checker for the key event decoder: tracks requests, predicts key events and compares results.
`timescale 1ns / 1ps

module skd_checker #(
	parameter int NUM_KEYS = 65
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [7:0]                   scan_byte,
	input  logic                         push,
	input  logic                         full,
	input  logic [skd_pkg::KEY_W-1:0]    key_number,
	input  logic                         key_down,
	input  logic [skd_pkg::EVENT_W-1:0]  event_number,
	input  logic                         empty,
	input  logic                         pop,
	output int                           fail_count,
	output int                           events_owed
);

	import skd_pkg::*;

	localparam int TABLE_LEN = 65;
	localparam int REPORT_MAX = 10;

	typedef struct {
		logic [KEY_W-1:0]   key;
		logic               down;
		logic [EVENT_W-1:0] number;
	} key_event_s;

	// Scan-code address {extended, code} of each key, in key index order
	localparam logic [7:0] KEY_ADDR [TABLE_LEN] = '{
		8'h0B, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
		8'h09, 8'h0A,
		8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
		8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
		8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
		8'h15, 8'h2C,
		8'h39, 8'h0E, 8'h1C, 8'h01,
		8'hCB, 8'hC8, 8'hCD, 8'hD0,
		8'h2A, 8'h36, 8'h1D, 8'h9D, 8'h38, 8'hB8,
		8'h52, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47,
		8'h48, 8'h49,
		8'hB7, 8'hB5, 8'h4E, 8'h4A, 8'h9C
	};

	logic               map_valid [256];
	logic [KEY_W-1:0]   map_key   [256];
	logic               ext_armed;
	logic [NUM_KEYS-1:0] held_keys;
	logic [EVENT_W-1:0] event_count;
	key_event_s         owed_events [$];
	int                 mismatches;

	// Build the key map from the table
	initial begin
		for (int a = 0; a < 256; a++) begin
			map_valid[a] = 1'b0;
			map_key[a]   = '0;
		end
		for (int i = 0; i < TABLE_LEN; i++) begin
			if (i < NUM_KEYS) begin
				map_valid[KEY_ADDR[i]] = 1'b1;
				map_key[KEY_ADDR[i]]   = KEY_W'(i);
			end
		end
	end

	// Advance the decoder state by one byte and queue any event it gives
	task automatic decode_scan_byte(input logic [7:0] b);
		logic [7:0]       addr;
		logic             release_flag;
		logic [KEY_W-1:0] k;
		key_event_s       ev;
		if (b == PREFIX_BYTE) begin
			ext_armed = 1'b1;
			return;
		end
		release_flag = b[RELEASE_BIT];
		addr         = {ext_armed, b[6:0]};
		ext_armed    = 1'b0;
		if (!map_valid[addr])
			return;
		k = map_key[addr];
		if (int'(k) >= NUM_KEYS)
			return;
		if (held_keys[k] == !release_flag)
			return;
		held_keys[k] = !release_flag;
		ev.key       = k;
		ev.down      = !release_flag;
		ev.number    = event_count;
		event_count  = event_count + 1'b1;
		owed_events.push_back(ev);
	endtask

	// Count a failure, reporting only the first few
	task automatic note_failure(input string what, input key_event_s want);
		mismatches = mismatches + 1;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s: expected key %0d down %0d number %0d, got key %0d down %0d number %0d",
				$realtime, what, want.key, want.down, want.number,
				key_number, key_down, event_number);
	endtask

	// Check results first, then take the request of this edge
	always @(posedge clk or negedge arst_n) begin
		key_event_s want;
		if (!arst_n) begin
			ext_armed   = 1'b0;
			held_keys   = '0;
			event_count = '0;
			owed_events.delete();
			mismatches  = 0;
			fail_count  <= 0;
			events_owed <= 0;
		end else begin
			if (pop && !empty) begin
				if (owed_events.size() == 0) begin
					want = '{key: '0, down: 1'b0, number: '0};
					note_failure("unexpected key event", want);
				end else begin
					want = owed_events.pop_front();
					if (key_number !== want.key || key_down !== want.down ||
					    event_number !== want.number)
						note_failure("key event mismatch", want);
				end
			end
			if (push && !full)
				decode_scan_byte(scan_byte);
			fail_count  <= mismatches;
			events_owed <= owed_events.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the key event decoder testbench: clock, reset, byte stimulus, result draining and verdict.
`timescale 1ns / 1ps

module testbench;

	import skd_pkg::*;

	localparam int NUM_KEYS     = 65;
	localparam int KEY_BYTES    = 820;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 10;

	logic                 clk;
	logic                 arst_n;
	logic [7:0]           scan_byte;
	logic                 push;
	logic                 full;
	logic [KEY_W-1:0]     key_number;
	logic                 key_down;
	logic [EVENT_W-1:0]   event_number;
	logic                 empty;
	logic                 pop;
	int                   fail_count;
	int                   events_owed;

	scancode_key_event_decoder_unit #(
		.NUM_KEYS          (NUM_KEYS),
		.EVENT_COUNT_WIDTH (32)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_byte    (scan_byte),
		.push         (push),
		.full         (full),
		.key_number   (key_number),
		.key_down     (key_down),
		.event_number (event_number),
		.empty        (empty),
		.pop          (pop)
	);

	skd_checker #(
		.NUM_KEYS (NUM_KEYS)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_byte    (scan_byte),
		.push         (push),
		.full         (full),
		.key_number   (key_number),
		.key_down     (key_down),
		.event_number (event_number),
		.empty        (empty),
		.pop          (pop),
		.fail_count   (fail_count),
		.events_owed  (events_owed)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Pick an idle length: mostly none or short, now and then long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Offer one byte after a random gap and hold it until the request is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_length();
		repeat (gap) begin
			push      <= 1'b0;
			scan_byte <= 8'($urandom);
			@(posedge clk);
		end
		push      <= 1'b1;
		scan_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Send a random mapped key press or release, with its prefix (now and then twice) where it needs one
	task automatic send_key_stroke();
		logic [7:0] addr;
		lookup_t    hit;
		do begin
			addr = 8'($urandom);
			hit  = key_lookup(addr);
		end while (!hit.valid);
		if (addr[7]) begin
			send_byte(PREFIX_BYTE);
			if ($urandom_range(0, 9) == 0)
				send_byte(PREFIX_BYTE);
		end
		send_byte({1'($urandom), addr[6:0]});
	endtask

	// Drain results with random stalls
	initial begin
		int gap;
		pop = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			gap = idle_length();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// End the run when nothing is taken for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle = 0;
			else
				idle = idle + 1;
		end
		$display("FAILURE");
		$finish;
	end

	// Reset, directed bytes, random bytes, drain and verdict
	initial begin
		int sent;
		arst_n    = 1'b0;
		push      = 1'b0;
		scan_byte = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unmapped codes at the byte extremes
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h80);
		// repeated prefix, then right control press and release
		send_byte(PREFIX_BYTE);
		send_byte(PREFIX_BYTE);
		send_byte(8'h1D);
		send_byte(PREFIX_BYTE);
		send_byte(8'h9D);
		// left control: press, repeat press, release, release of a key not held
		send_byte(8'h1D);
		send_byte(8'h1D);
		send_byte(8'h9D);
		send_byte(8'h9D);
		// the byte E1 is no prefix here and only drops the extended flag
		send_byte(PREFIX_BYTE);
		send_byte(8'hE1);
		send_byte(8'h38);
		// extended and plain key sharing one code
		send_byte(PREFIX_BYTE);
		send_byte(8'h4B);
		send_byte(8'h4B);
		send_byte(PREFIX_BYTE);
		send_byte(8'hCB);
		send_byte(8'hCB);
		// unmapped extended code drops the prefix before a plain key
		send_byte(PREFIX_BYTE);
		send_byte(8'h00);
		send_byte(8'h1C);
		send_byte(PREFIX_BYTE);
		send_byte(8'h1C);
		send_byte(PREFIX_BYTE);
		send_byte(8'h9C);
		send_byte(8'h9C);

		// mostly well-formed key strokes, some noise bytes
		sent = 0;
		while (sent < KEY_BYTES) begin
			if ($urandom_range(0, 99) < 80)
				send_key_stroke();
			else
				send_byte(8'($urandom));
			sent = sent + 1;
		end
		push <= 1'b0;
		@(posedge clk);

		// hold until every owed event has come, then let the pipeline settle
		while (events_owed != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && events_owed == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/skd_pkg.sv
rtl/core/skd_front.sv
rtl/core/skd_back.sv
rtl/core/scancode_key_event_decoder_unit.sv
dv/skd_checker.sv
dv/testbench.sv
